@@ sv/i2cm_pkg.sv @@
// Shared types and constants of the I2C bit-level master.
// Used by i2cm_seq and i2c_bit_level_master; depends on nothing else.
`default_nettype none

package i2cm_pkg;

    // Command codes carried with each tick.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_POLL    = 8'd1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [9:0]  ACK_POLL_RESET    = 10'd200;

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [14:0] {
        PH_IDLE      = 15'b000000000000001,
        PH_ST_HOLD   = 15'b000000000000010,
        PH_ST_LOW    = 15'b000000000000100,
        PH_SP_LOW    = 15'b000000000001000,
        PH_SP_HIGH   = 15'b000000000010000,
        PH_SP_REL    = 15'b000000000100000,
        PH_WR_LOW    = 15'b000000001000000,
        PH_WR_HIGH   = 15'b000000010000000,
        PH_WR_REL    = 15'b000000100000000,
        PH_WR_ACKDLY = 15'b000001000000000,
        PH_WR_POLL   = 15'b000010000000000,
        PH_RD_HIGH   = 15'b000100000000000,
        PH_RD_LOW    = 15'b001000000000000,
        PH_AK_LOW    = 15'b010000000000000,
        PH_AK_HIGH   = 15'b100000000000000
    } phase_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       ack_missing;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [9:0]  ack_poll_limit;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/i2cm_seq.sv @@
// Bus sequencer of the I2C master: sequence state registers and the per-tick step logic.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire i2cm_pkg::item_t   item,
    input  wire i2cm_pkg::cfg_t    cfg,
    output i2cm_pkg::result_t      result
);

    i2cm_pkg::phase_t phase_reg, phase_next;
    logic [15:0] delay_reg, delay_next;
    logic [9:0]  poll_reg, poll_next;
    logic [3:0]  bit_idx_reg, bit_idx_next;
    logic [7:0]  shift_reg, shift_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_choice_reg, ack_choice_next;
    logic [7:0]  rx_hold_reg, rx_hold_next;
    logic        nack_reg, nack_next;
    logic        done;

    always_comb begin
        logic [9:0] pc;
        logic [3:0] bit_inc;
        pc              = (phase_reg == i2cm_pkg::PH_WR_ACKDLY) ? 10'd0 : poll_reg;
        bit_inc         = bit_idx_reg + 4'd1;
        phase_next      = phase_reg;
        delay_next      = delay_reg;
        poll_next       = poll_reg;
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_choice_next = ack_choice_reg;
        rx_hold_next    = rx_hold_reg;
        nack_next       = nack_reg;
        done            = 1'b0;

        if (phase_reg == i2cm_pkg::PH_IDLE) begin
            case (item.operation)
                i2cm_pkg::OP_START: begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_ST_HOLD;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::OP_STOP: begin
                    sda_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_SP_LOW;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::OP_WRITE: begin
                    nack_next    = 1'b0;
                    bit_idx_next = 4'd0;
                    scl_next     = 1'b0;
                    sda_next     = item.tx_byte[7];
                    shift_next   = {item.tx_byte[6:0], 1'b0};
                    phase_next   = i2cm_pkg::PH_WR_LOW;
                    delay_next   = cfg.half_period_ticks;
                end
                i2cm_pkg::OP_READ: begin
                    ack_choice_next = item.send_ack;
                    sda_next        = 1'b1;
                    shift_next      = 8'd0;
                    bit_idx_next    = 4'd0;
                    scl_next        = 1'b1;
                    phase_next      = i2cm_pkg::PH_RD_HIGH;
                    delay_next      = cfg.half_period_ticks;
                end
                default: begin
                end
            endcase
        end else if (phase_reg != i2cm_pkg::PH_WR_REL && phase_reg != i2cm_pkg::PH_WR_POLL
                     && delay_reg > 16'd1) begin
            delay_next = delay_reg - 16'd1;
        end else begin
            case (phase_reg)
                i2cm_pkg::PH_ST_HOLD: begin
                    sda_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_ST_LOW;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::PH_ST_LOW: begin
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                i2cm_pkg::PH_SP_LOW: begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_SP_HIGH;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::PH_SP_HIGH: begin
                    sda_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_SP_REL;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::PH_SP_REL: begin
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                i2cm_pkg::PH_WR_LOW: begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_WR_HIGH;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::PH_WR_HIGH: begin
                    scl_next     = 1'b0;
                    bit_idx_next = bit_inc;
                    if (bit_inc < 4'd8) begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = i2cm_pkg::PH_WR_LOW;
                        delay_next = cfg.half_period_ticks;
                    end else begin
                        // Release SDA in PH_WR_REL before SCL rises for the ACK bit.
                        sda_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_WR_REL;
                    end
                end
                i2cm_pkg::PH_WR_REL: begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_WR_ACKDLY;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::PH_WR_ACKDLY, i2cm_pkg::PH_WR_POLL: begin
                    poll_next = pc;
                    if (!item.sda_in) begin
                        scl_next   = 1'b0;
                        phase_next = i2cm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end else if (pc >= cfg.ack_poll_limit) begin
                        // No ACK within the poll budget: flag it and run a stop.
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        nack_next  = 1'b1;
                        phase_next = i2cm_pkg::PH_SP_LOW;
                        delay_next = cfg.half_period_ticks;
                    end else begin
                        poll_next  = pc + 10'd1;
                        phase_next = i2cm_pkg::PH_WR_POLL;
                    end
                end
                i2cm_pkg::PH_RD_HIGH: begin
                    shift_next = {shift_reg[6:0], item.sda_in};
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_RD_LOW;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::PH_RD_LOW: begin
                    bit_idx_next = bit_inc;
                    if (bit_inc < 4'd8) begin
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_RD_HIGH;
                    end else begin
                        sda_next   = !ack_choice_reg;
                        phase_next = i2cm_pkg::PH_AK_LOW;
                    end
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::PH_AK_LOW: begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_AK_HIGH;
                    delay_next = cfg.half_period_ticks;
                end
                i2cm_pkg::PH_AK_HIGH: begin
                    scl_next     = 1'b0;
                    sda_next     = 1'b1;
                    rx_hold_next = shift_reg;
                    phase_next   = i2cm_pkg::PH_IDLE;
                    done         = 1'b1;
                end
                default: begin
                    phase_next = i2cm_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= i2cm_pkg::PH_IDLE;
            delay_reg      <= 16'd0;
            poll_reg       <= 10'd0;
            bit_idx_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            rx_hold_reg    <= 8'd0;
            nack_reg       <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            delay_reg      <= delay_next;
            poll_reg       <= poll_next;
            bit_idx_reg    <= bit_idx_next;
            shift_reg      <= shift_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_choice_reg <= ack_choice_next;
            rx_hold_reg    <= rx_hold_next;
            nack_reg       <= nack_next;
        end
    end

    always_comb begin
        result.scl_out     = scl_next;
        result.sda_out     = sda_next;
        result.busy_res    = (phase_next != i2cm_pkg::PH_IDLE);
        result.done_res    = done;
        result.rx_byte     = rx_hold_next;
        result.ack_missing = nack_next;
    end

endmodule

`default_nettype wire

@@ sv/i2c_bit_level_master.sv @@
// Top level of the I2C bit-level master: stream ports, input and result registers,
// configuration registers. Depends on i2cm_pkg and i2cm_seq.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   tuser: operation; tdata: tx_byte, send_ack, sda_in
//  m_        out        m_tvalid/m_tready   tdata: scl, sda, busy, done, rx_byte, ack_missing
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One tick item per cycle is sustained while the result is not stalled; each item lands
// in the input register, is stepped through the sequencer once the result register can
// take it and is then offered from the result register.
// A stalled result holds the result register and the sequencer; the input register
// still takes one more item. Reset (aresetn low) empties both registers and restores
// the sequencer and configuration to their reset values.
`default_nettype none

module i2c_bit_level_master (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [i2cm_pkg::S_TDATA_W-1:0]      s_tdata,   // tx_byte[7:0], send_ack, sda_in
    input  wire logic [i2cm_pkg::S_TUSER_W-1:0]      s_tuser,   // operation[2:0]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // scl_out, sda_out, busy_res, done_res, rx_byte[7:0], ack_missing, zero fill
    output logic [i2cm_pkg::M_TDATA_W-1:0]           m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [i2cm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic              in_valid_reg;
    i2cm_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    i2cm_pkg::result_t out_res_reg;
    i2cm_pkg::cfg_t    cfg_reg;
    i2cm_pkg::result_t step_res;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.operation <= s_tuser[2:0];
            in_item_reg.tx_byte   <= s_tdata[7:0];
            in_item_reg.send_ack  <= s_tdata[8];
            in_item_reg.sda_in    <= s_tdata[9];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= i2cm_pkg::HALF_PERIOD_RESET;
            cfg_reg.ack_poll_limit    <= i2cm_pkg::ACK_POLL_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == i2cm_pkg::REG_HALF_PERIOD) begin
                cfg_reg.half_period_ticks <= cfg_data;
            end else if (cfg_index == i2cm_pkg::REG_ACK_POLL) begin
                cfg_reg.ack_poll_limit <= cfg_data[9:0];
            end
        end
    end

    i2cm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg};

endmodule

`default_nettype wire
